### hw/rtl/tlbt_pkg.sv
// shared types and constants for the two-wire link byte transceiver
package tlbt_pkg;

    localparam int unsigned CmdW     = 2;
    localparam int unsigned ByteW    = 8;
    localparam int unsigned BitCntW  = 4;
    localparam int unsigned CfgIdxW  = 1;
    localparam int unsigned CfgDataW = 8;

    // command codes
    localparam logic [CmdW-1:0] CMD_TICK = 2'd0;
    localparam logic [CmdW-1:0] CMD_SEND = 2'd1;
    localparam logic [CmdW-1:0] CMD_RECV = 2'd2;

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] CFG_PRE_BIT_DELAY = 1'd0;
    localparam logic [CfgIdxW-1:0] CFG_SETTLE_DELAY  = 1'd1;

    localparam logic [CfgDataW-1:0] PreBitDelayReset = 8'd64;
    localparam logic [CfgDataW-1:0] SettleDelayReset = 8'd16;

    localparam logic [BitCntW-1:0] BitsPerByte = 4'd8;

    typedef enum logic [3:0] {
        PH_IDLE        = 4'd0,
        PH_TX_WAITHIGH = 4'd1,
        PH_TX_PRE      = 4'd2,
        PH_TX_WAITACK  = 4'd3,
        PH_TX_SETTLE1  = 4'd4,
        PH_TX_WAITREL  = 4'd5,
        PH_TX_SETTLE2  = 4'd6,
        PH_RX_WAITLOW  = 4'd7,
        PH_RX_ACKONE   = 4'd8,
        PH_RX_ACKZERO  = 4'd9
    } t_phase;

    typedef struct packed {
        logic [CmdW-1:0]  cmd;
        logic [ByteW-1:0] tx_byte;
        logic             line_one_high;
        logic             line_zero_high;
    } t_in_item;

    typedef struct packed {
        logic             drive_one_low;
        logic             drive_zero_low;
        logic             busy_res;
        logic             done_res;
        logic [ByteW-1:0] rx_byte;
        logic             fault;
    } t_out_item;

    typedef struct packed {
        logic [CfgDataW-1:0] pre_bit_delay;
        logic [CfgDataW-1:0] settle_delay;
    } t_cfg;

endpackage

### hw/rtl/tlbt_if.sv
// valid/ready channel interfaces for tick items and result items
interface tlbt_in_if;
    logic                        valid;
    logic                        ready;
    logic [tlbt_pkg::CmdW-1:0]   cmd;
    logic [tlbt_pkg::ByteW-1:0]  tx_byte;
    logic                        line_one_high;
    logic                        line_zero_high;

    modport source (output valid, cmd, tx_byte, line_one_high, line_zero_high,
                    input ready);
    modport sink   (input valid, cmd, tx_byte, line_one_high, line_zero_high,
                    output ready);
endinterface

interface tlbt_out_if;
    logic                        valid;
    logic                        ready;
    logic                        drive_one_low;
    logic                        drive_zero_low;
    logic                        busy_res;
    logic                        done_res;
    logic [tlbt_pkg::ByteW-1:0]  rx_byte;
    logic                        fault;

    modport source (output valid, drive_one_low, drive_zero_low, busy_res, done_res,
                           rx_byte, fault,
                    input ready);
    modport sink   (input valid, drive_one_low, drive_zero_low, busy_res, done_res,
                          rx_byte, fault,
                    output ready);
endinterface

### hw/rtl/two_wire_link_byte_transceiver.sv
// top level: input register, link state machine, result register
//
//  channel   dir  handshake       payload
//  i_item    in   valid / ready   cmd, tx_byte, line_one_high, line_zero_high
//  o_res     out  valid / ready   drive_one_low, drive_zero_low, busy_res,
//                                 done_res, rx_byte, fault
//  cfg       in   i_cfg_we        i_cfg_idx, i_cfg_data
//
// one item a cycle sustained while results are taken; an item passes through the
// input register, then the state machine step into the result register
// synchronous active-low reset returns to idle with delays 64 and 16
// a stalled result holds the result register; the input register still takes
// one more item if it is empty, then ready drops until the result is taken
module two_wire_link_byte_transceiver (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    tlbt_in_if.sink                         i_item,
    tlbt_out_if.source                      o_res,
    input  logic                            i_cfg_we,
    input  logic [tlbt_pkg::CfgIdxW-1:0]    i_cfg_idx,
    input  logic [tlbt_pkg::CfgDataW-1:0]   i_cfg_data
);

    logic                  r_in_valid;
    tlbt_pkg::t_in_item    r_in;
    logic                  r_out_valid;
    tlbt_pkg::t_out_item   r_out;
    tlbt_pkg::t_out_item   step_res;
    tlbt_pkg::t_cfg        cfg;
    logic                  step;
    logic                  in_take;

    assign step    = r_in_valid && (!r_out_valid || o_res.ready);
    assign in_take = i_item.valid && i_item.ready;
    assign i_item.ready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in.cmd            <= i_item.cmd;
            r_in.tx_byte        <= i_item.tx_byte;
            r_in.line_one_high  <= i_item.line_one_high;
            r_in.line_zero_high <= i_item.line_zero_high;
        end
    end

    tlbt_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    tlbt_fsm u_fsm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_item  (r_in),
        .i_cfg   (cfg),
        .o_res   (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= step_res;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.drive_one_low  = r_out.drive_one_low;
    assign o_res.drive_zero_low = r_out.drive_zero_low;
    assign o_res.busy_res       = r_out.busy_res;
    assign o_res.done_res       = r_out.done_res;
    assign o_res.rx_byte        = r_out.rx_byte;
    assign o_res.fault          = r_out.fault;

endmodule

### hw/rtl/tlbt_cfg.sv
// configuration registers: pre-bit delay and settle delay
module tlbt_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [tlbt_pkg::CfgIdxW-1:0]       i_cfg_idx,
    input  logic [tlbt_pkg::CfgDataW-1:0]      i_cfg_data,
    output tlbt_pkg::t_cfg                     o_cfg
);

    logic [tlbt_pkg::CfgDataW-1:0] r_pre_bit_delay;
    logic [tlbt_pkg::CfgDataW-1:0] r_settle_delay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre_bit_delay <= tlbt_pkg::PreBitDelayReset;
            r_settle_delay  <= tlbt_pkg::SettleDelayReset;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                tlbt_pkg::CFG_PRE_BIT_DELAY: r_pre_bit_delay <= i_cfg_data;
                tlbt_pkg::CFG_SETTLE_DELAY:  r_settle_delay  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg.pre_bit_delay = r_pre_bit_delay;
    assign o_cfg.settle_delay  = r_settle_delay;

endmodule

### hw/rtl/tlbt_fsm.sv
// link state machine: one tick per step, computes the result of that tick
module tlbt_fsm (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  tlbt_pkg::t_in_item    i_item,
    input  tlbt_pkg::t_cfg        i_cfg,
    output tlbt_pkg::t_out_item   o_res
);

    tlbt_pkg::t_phase                  r_phase, n_phase;
    logic [tlbt_pkg::BitCntW-1:0]      r_bit_count, n_bit_count;
    logic [tlbt_pkg::ByteW-1:0]        r_shift_byte, n_shift_byte;
    logic [tlbt_pkg::CfgDataW-1:0]     r_wait_count, n_wait_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= tlbt_pkg::PH_IDLE;
            r_bit_count  <= '0;
            r_shift_byte <= '0;
            r_wait_count <= '0;
        end else if (i_step) begin
            r_phase      <= n_phase;
            r_bit_count  <= n_bit_count;
            r_shift_byte <= n_shift_byte;
            r_wait_count <= n_wait_count;
        end
    end

    always_comb begin
        logic                          mine_one;
        logic                          one_hi;
        logic                          zero_hi;
        logic [tlbt_pkg::BitCntW-1:0]  cnt_inc;
        logic [tlbt_pkg::CfgDataW-1:0] wait_inc;
        logic                          done;
        logic                          flt;
        logic [tlbt_pkg::ByteW-1:0]    rxo;

        mine_one = r_shift_byte[0];
        one_hi   = i_item.line_one_high;
        zero_hi  = i_item.line_zero_high;
        cnt_inc  = r_bit_count + tlbt_pkg::BitCntW'(1);
        wait_inc = r_wait_count + tlbt_pkg::CfgDataW'(1);
        done     = 1'b0;
        flt      = 1'b0;
        rxo      = '0;

        n_phase      = r_phase;
        n_bit_count  = r_bit_count;
        n_shift_byte = r_shift_byte;
        n_wait_count = r_wait_count;

        unique case (r_phase)
            tlbt_pkg::PH_IDLE: begin
                if (i_item.cmd == tlbt_pkg::CMD_SEND) begin
                    n_shift_byte = i_item.tx_byte;
                    n_bit_count  = '0;
                    n_wait_count = '0;
                    n_phase      = tlbt_pkg::PH_TX_WAITHIGH;
                end else if (i_item.cmd == tlbt_pkg::CMD_RECV) begin
                    n_shift_byte = '0;
                    n_bit_count  = '0;
                    n_wait_count = '0;
                    n_phase      = tlbt_pkg::PH_RX_WAITLOW;
                end
            end
            tlbt_pkg::PH_TX_WAITHIGH: begin
                if (one_hi && zero_hi) begin
                    n_wait_count = '0;
                    n_phase      = tlbt_pkg::PH_TX_PRE;
                end
            end
            tlbt_pkg::PH_TX_PRE: begin
                if (r_wait_count >= i_cfg.pre_bit_delay) begin
                    n_phase = tlbt_pkg::PH_TX_WAITACK;
                end else begin
                    n_wait_count = wait_inc;
                end
            end
            tlbt_pkg::PH_TX_WAITACK: begin
                // partner acknowledges on the opposite line
                if (mine_one ? !zero_hi : !one_hi) begin
                    n_wait_count = '0;
                    n_phase      = tlbt_pkg::PH_TX_SETTLE1;
                end
            end
            tlbt_pkg::PH_TX_SETTLE1: begin
                if (r_wait_count >= i_cfg.settle_delay) begin
                    n_phase = tlbt_pkg::PH_TX_WAITREL;
                end else begin
                    n_wait_count = wait_inc;
                end
            end
            tlbt_pkg::PH_TX_WAITREL: begin
                if (mine_one ? zero_hi : one_hi) begin
                    n_wait_count = '0;
                    n_phase      = tlbt_pkg::PH_TX_SETTLE2;
                end
            end
            tlbt_pkg::PH_TX_SETTLE2: begin
                if (r_wait_count >= i_cfg.settle_delay) begin
                    n_shift_byte = {1'b0, r_shift_byte[tlbt_pkg::ByteW-1:1]};
                    n_bit_count  = cnt_inc;
                    if (cnt_inc >= tlbt_pkg::BitsPerByte) begin
                        done    = 1'b1;
                        n_phase = tlbt_pkg::PH_IDLE;
                    end else begin
                        n_phase = tlbt_pkg::PH_TX_WAITHIGH;
                    end
                end else begin
                    n_wait_count = wait_inc;
                end
            end
            tlbt_pkg::PH_RX_WAITLOW: begin
                // both lines low is a broken link: give up
                if (!one_hi && !zero_hi) begin
                    flt     = 1'b1;
                    n_phase = tlbt_pkg::PH_IDLE;
                end else if (!one_hi) begin
                    n_phase = tlbt_pkg::PH_RX_ACKONE;
                end else if (!zero_hi) begin
                    n_phase = tlbt_pkg::PH_RX_ACKZERO;
                end
            end
            tlbt_pkg::PH_RX_ACKONE, tlbt_pkg::PH_RX_ACKZERO: begin
                if ((r_phase == tlbt_pkg::PH_RX_ACKONE) ? one_hi : zero_hi) begin
                    n_shift_byte = {r_phase == tlbt_pkg::PH_RX_ACKONE,
                                    r_shift_byte[tlbt_pkg::ByteW-1:1]};
                    n_bit_count  = cnt_inc;
                    if (cnt_inc >= tlbt_pkg::BitsPerByte) begin
                        done    = 1'b1;
                        rxo     = n_shift_byte;
                        n_phase = tlbt_pkg::PH_IDLE;
                    end else begin
                        n_phase = tlbt_pkg::PH_RX_WAITLOW;
                    end
                end
            end
            default: begin
                n_phase = tlbt_pkg::PH_IDLE;
            end
        endcase

        // line drive follows the state after this tick
        o_res.drive_one_low  = 1'b0;
        o_res.drive_zero_low = 1'b0;
        if (n_phase == tlbt_pkg::PH_TX_WAITACK || n_phase == tlbt_pkg::PH_TX_SETTLE1) begin
            o_res.drive_one_low  = n_shift_byte[0];
            o_res.drive_zero_low = !n_shift_byte[0];
        end else if (n_phase == tlbt_pkg::PH_RX_ACKONE) begin
            o_res.drive_zero_low = 1'b1;
        end else if (n_phase == tlbt_pkg::PH_RX_ACKZERO) begin
            o_res.drive_one_low = 1'b1;
        end
        o_res.busy_res = (n_phase != tlbt_pkg::PH_IDLE);
        o_res.done_res = done;
        o_res.rx_byte  = rxo;
        o_res.fault    = flt;
    end

endmodule

### hw/rtl/tlbt_checker.sv
// port-level checks on the transceiver result channel, bound to the top level
module tlbt_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic                          i_drive_one_low,
    input  logic                          i_drive_zero_low,
    input  logic                          i_busy_res,
    input  logic                          i_done_res,
    input  logic [tlbt_pkg::ByteW-1:0]    i_rx_byte,
    input  logic                          i_fault
);

    // a waiting result keeps its rx byte and its done and busy flags
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_rx_byte) && $stable(i_done_res)
             && $stable(i_busy_res)))
        else $error("result changed while stalled");

    // the link never pulls both lines at once
    a_one_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_drive_one_low && i_drive_zero_low))
        else $error("both lines driven low");

    // finishing a byte or faulting leaves the block idle and the lines free
    a_end_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_done_res || i_fault)) |->
            (!i_busy_res && !i_drive_one_low && !i_drive_zero_low))
        else $error("busy or driving at end of transfer");

    // fault and done are exclusive
    a_fault_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_fault && i_done_res))
        else $error("fault and done together");

    // received data only shows on a done item
    a_rx_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_rx_byte != '0)) |-> i_done_res)
        else $error("rx byte without done");

endmodule

bind two_wire_link_byte_transceiver tlbt_checker u_tlbt_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_res.valid),
    .i_out_ready      (o_res.ready),
    .i_drive_one_low  (o_res.drive_one_low),
    .i_drive_zero_low (o_res.drive_zero_low),
    .i_busy_res       (o_res.busy_res),
    .i_done_res       (o_res.done_res),
    .i_rx_byte        (o_res.rx_byte),
    .i_fault          (o_res.fault)
);
